[src/pcrng_pkg.sv]
`timescale 1ns / 1ps

package pcrng_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned INDEX_W     = 64;
    localparam int unsigned FRAC_W      = 24;
    localparam int unsigned THRESH_W    = 25;
    localparam int unsigned FRAC_SHIFT  = 8;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam int unsigned ROUND_COUNT_DEF = 10;

    // Philox 2x32 round multiplier and Weyl key increment.
    localparam logic [WORD_W-1:0] PHILOX_MUL  = 32'hD256D193;
    localparam logic [WORD_W-1:0] PHILOX_WEYL = 32'h9E3779B9;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SEED       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_SEQ     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_THRESHOLD = 8'd2;

    // One slot of the round chain: a counter pair and its round key.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] key;
    } t_lane;

endpackage

[src/philox_counter_rng_core.sv]
`timescale 1ns / 1ps

// Philox 2x32 counter-based random generator.
//
// Command channel: an element index is accepted at a rising clock edge at
// which start is high and busy is low. Busy is never raised, so a new index
// may be presented in every cycle and the block sustains one transaction per
// clock cycle.
//
// Result channel: each result sits on the o_word_zero, o_word_one,
// o_uniform_fraction and o_draw_bit ports for exactly one cycle, marked by
// o_valid, and is registered in turn in the input register, in each round
// cell and in the output register before it appears.
// The receiver cannot stall; results leave in
// the order the indices came in.
//
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index and
// data. Ready is always high. Index 0 is the key seed, 1 the stream sequence,
// 2 the keep threshold (25 bits); other indexes are ignored. Registers are
// only to be written while no transaction is in flight.
//
// Reset (synchronous, active low) clears the configuration registers to zero
// and drops every transaction in flight, whose results never appear.
module philox_counter_rng_core
    import pcrng_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [INDEX_W-1:0]     i_element_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_word_zero,
    output logic [WORD_W-1:0]      o_word_one,
    output logic [FRAC_W-1:0]      o_uniform_fraction,
    output logic                   o_draw_bit
);

    // Configuration registers.
    logic [WORD_W-1:0]   r_key_seed;
    logic [WORD_W-1:0]   r_stream_seq;
    logic [THRESH_W-1:0] r_keep_threshold;

    logic cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed       <= '0;
            r_stream_seq     <= '0;
            r_keep_threshold <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_KEY_SEED:       r_key_seed       <= i_cfg_data;
                CFG_STREAM_SEQ:     r_stream_seq     <= i_cfg_data;
                CFG_KEEP_THRESHOLD: r_keep_threshold <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never backs up, so the command channel is always open.
    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Input register: forms the counter pair and loads the initial key.
    // The upper counter word wraps mod 2^32; its carry is dropped.
    t_lane n_in_lane;
    t_lane r_in_lane;

    always_comb begin
        n_in_lane.valid = accept;
        n_in_lane.w0    = i_element_index[WORD_W-1:0];
        n_in_lane.w1    = r_stream_seq + i_element_index[INDEX_W-1:WORD_W];
        n_in_lane.key   = r_key_seed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_lane.valid <= 1'b0;
        end else begin
            r_in_lane.valid <= n_in_lane.valid;
        end
        r_in_lane.w0  <= n_in_lane.w0;
        r_in_lane.w1  <= n_in_lane.w1;
        r_in_lane.key <= n_in_lane.key;
    end

    // Chain of round cells; each slot advances one cell per cycle and carries
    // its own key, which each cell bumps by the Weyl constant.
    t_lane lane [0:ROUND_COUNT];

    assign lane[0] = r_in_lane;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        pcrng_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (lane[g]),
            .o_lane (lane[g+1])
        );
    end

    // Output register: the fraction is the top 24 bits of word zero, and the
    // draw bit compares it against the 25-bit threshold, so a threshold of
    // zero never draws and one at or above 2^24 always draws.
    t_lane             last_lane;
    logic [FRAC_W-1:0] n_frac;
    logic              n_draw;

    logic              r_valid;
    logic [WORD_W-1:0] r_word_zero;
    logic [WORD_W-1:0] r_word_one;
    logic [FRAC_W-1:0] r_frac;
    logic              r_draw;

    assign last_lane = lane[ROUND_COUNT];
    assign n_frac    = last_lane.w0[WORD_W-1:FRAC_SHIFT];
    assign n_draw    = ({1'b0, n_frac} < r_keep_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last_lane.valid;
        end
        r_word_zero <= last_lane.w0;
        r_word_one  <= last_lane.w1;
        r_frac      <= n_frac;
        r_draw      <= n_draw;
    end

    assign o_valid            = r_valid;
    assign o_word_zero        = r_word_zero;
    assign o_word_one         = r_word_one;
    assign o_uniform_fraction = r_frac;
    assign o_draw_bit         = r_draw;

endmodule

[src/pcrng_cell.sv]
`timescale 1ns / 1ps

// One Philox round. The cell takes the slot of its upstream neighbor, applies
// the round, bumps the key and hands the result downstream in the next cycle.
module pcrng_cell
    import pcrng_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_lane i_lane,
    output t_lane o_lane
);

    logic [2*WORD_W-1:0] n_prod;
    t_lane               n_lane;
    t_lane               r_lane;

    always_comb begin
        n_prod       = {{WORD_W{1'b0}}, PHILOX_MUL} * {{WORD_W{1'b0}}, i_lane.w0};
        n_lane.valid = i_lane.valid;
        n_lane.w0    = n_prod[2*WORD_W-1:WORD_W] ^ i_lane.key ^ i_lane.w1;
        n_lane.w1    = n_prod[WORD_W-1:0];
        n_lane.key   = i_lane.key + PHILOX_WEYL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
        r_lane.w0  <= n_lane.w0;
        r_lane.w1  <= n_lane.w1;
        r_lane.key <= n_lane.key;
    end

    assign o_lane = r_lane;

endmodule

[src/pcrng_checker.sv]
`timescale 1ns / 1ps

module pcrng_checker
    import pcrng_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [WORD_W-1:0] o_word_zero,
    input logic [FRAC_W-1:0] o_uniform_fraction
);

    localparam int unsigned LATENCY = ROUND_COUNT + 2;

    // Every accepted index yields its result after the input register, every round cell and the output register.
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result missing after accepted transaction");

    // No result without an accepted index at the matching earlier edge.
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // Reset flushes the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // The fraction is the upper part of word zero.
    a_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_uniform_fraction == o_word_zero[WORD_W-1:FRAC_SHIFT]))
        else $error("fraction does not match word zero");

endmodule

bind philox_counter_rng_core pcrng_checker #(
    .ROUND_COUNT(ROUND_COUNT)
) u_pcrng_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_word_zero       (o_word_zero),
    .o_uniform_fraction(o_uniform_fraction)
);
